/* hw/rtl/lcoa_pkg.sv */
// shared types and constants for the lidar corridor alarm
// used by every module under hw/rtl; depends on nothing else
package lcoa_pkg;

	// angles in q3.12 radians
	localparam int unsigned ANG_PI      = 12868;
	localparam int unsigned ANG_HALF_PI = 6434;

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned Q30_ONE = 64'd1073741824;

	// floor(2^32 / ANG_PI), quotient of |angle| / pi is at most ten
	localparam logic [18:0] MOD_RECIP   = 19'd333771;
	localparam int unsigned MOD_SHIFT   = 32;

	localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BODY_RADIUS   = 3'd0,
		REG_SAFE_DISTANCE = 3'd1,
		REG_CONE_HALF     = 3'd2,
		REG_WINDOW_MIN    = 3'd3,
		REG_WINDOW_MAX    = 3'd4,
		REG_SCAN_START    = 3'd5,
		REG_ANGLE_STEP    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0]        body_radius;
		logic [15:0]        safe_distance;
		logic [12:0]        cone_half_angle;
		logic signed [14:0] window_min_angle;
		logic signed [14:0] window_max_angle;
		logic signed [14:0] scan_start_angle;
		logic [12:0]        angle_step;
	} cfg_t;

	// per-sample sideband that rides along the sine pipeline
	typedef struct packed {
		logic [15:0] range_sample;
		logic        last_sample;
		logic        counts;
		logic        in_cone;
		logic        near;
		logic [15:0] body_radius;
	} item_t;

endpackage

/* hw/rtl/lidar_corridor_obstacle_alarm_unit.sv */
// Lidar corridor obstacle alarm, top level.
// Input stream: one lidar range sample per request, tlast on the final sample
// of a scan. The block tracks each sample's angle (scan_start_angle, then
// angle_step per sample), keeps samples inside the configured window, and
// flags a block when a sample in the forward cone is within safe_distance, or
// a sample outside the cone has range*|sin(angle)| <= body_radius.
// Output stream: one request per scan, sent for the tlast sample, carrying
// the alarm for the whole scan; other samples produce no output.
// Path: the six-stage sine pipeline (mod-pi reduction, fold, index scaling,
// rom read) feeds a final multiply-compare, whose result is registered on
// m_axis. Throughput: one sample per cycle while the pipeline is not held
// by a stalled result.
// Each stage holds its content while the next one is full, so when the
// receiver stalls the pipeline fills and s_axis_tready drops; samples that
// give no output keep draining while a result waits.
// Reset: configuration takes its defaults, the pipeline empties, and the next
// sample starts a new scan. Configuration writes are taken on any cycle with
// cfg_we high and are meant for idle periods only.
// Depends on lcoa_pkg, lcoa_cfg_regs, lcoa_angle_track, lcoa_sine_pipe.
module lidar_corridor_obstacle_alarm_unit
	import lcoa_pkg::*;
#(
	parameter int unsigned SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata,  // [15:0] range_sample
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata,  // [0] alarm, [7:1] zero
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t        cfg;
	logic        in_take;
	logic [17:0] angle_mag;
	item_t       front_item;

	logic        fin_valid;
	logic        fin_ready;
	item_t       fin_item;
	logic [15:0] fin_sine;
	logic        fin_take;

	logic [31:0] corr_prod;
	logic [31:0] corr_lim;
	logic        hit;
	logic        out_load;

	logic        blocked_q;
	logic        tvalid_q;
	logic        alarm_q;

	lcoa_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign in_take = s_axis_tvalid && s_axis_tready;

	lcoa_angle_track u_angle (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.accept       (in_take),
		.range_sample (s_axis_tdata),
		.last_sample  (s_axis_tlast),
		.angle_mag    (angle_mag),
		.item         (front_item)
	);

	lcoa_sine_pipe #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_sine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mag    (angle_mag),
		.in_item   (front_item),
		.out_valid (fin_valid),
		.out_ready (fin_ready),
		.out_item  (fin_item),
		.out_sine  (fin_sine)
	);

	// corridor test: range * sine <= radius * 2^15, exact
	always_comb begin
		corr_prod = 32'(fin_item.range_sample) * 32'(fin_sine);
		corr_lim  = {1'b0, fin_item.body_radius, 15'b0};
		hit       = fin_item.counts &&
		            (fin_item.in_cone ? fin_item.near : (corr_prod <= corr_lim));
	end

	// only a last sample needs room in the output register
	assign fin_ready = !fin_item.last_sample || !tvalid_q || m_axis_tready;
	assign fin_take  = fin_valid && fin_ready;
	assign out_load  = fin_take && fin_item.last_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_q <= 1'b0;
			tvalid_q  <= 1'b0;
		end else begin
			if (fin_take) begin
				blocked_q <= fin_item.last_sample ? 1'b0 : (blocked_q || hit);
			end
			if (out_load) begin
				tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			alarm_q <= blocked_q || hit;
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = {7'b0, alarm_q};

`ifndef SYNTHESIS
	// a scan's block flag starts clean after its last sample leaves
	a_blocked_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> !blocked_q)
		else $error("blocked flag not cleared after end of scan");

	// an alarm raised by the current scan's last sample is what goes out
	a_alarm_from_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && hit) |=> (m_axis_tvalid && alarm_q))
		else $error("alarm lost for a blocking last sample");

	// a pending result is never overwritten while the receiver stalls
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(tvalid_q && !m_axis_tready) |-> !out_load)
		else $error("result overwritten while stalled");
`endif

endmodule

/* hw/rtl/lcoa_cfg_regs.sv */
// configuration register bank of the corridor alarm
// depends on lcoa_pkg for the register codes and the cfg_t bundle
module lcoa_cfg_regs
	import lcoa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.body_radius      <= 16'd200;
			cfg_q.safe_distance    <= 16'd500;
			cfg_q.cone_half_angle  <= 13'd1686;
			cfg_q.window_min_angle <= -15'sd6434;
			cfg_q.window_max_angle <= 15'sd6434;
			cfg_q.scan_start_angle <= -15'sd8192;
			cfg_q.angle_step       <= 13'd41;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BODY_RADIUS:   cfg_q.body_radius      <= cfg_wdata;
				REG_SAFE_DISTANCE: cfg_q.safe_distance    <= cfg_wdata;
				REG_CONE_HALF:     cfg_q.cone_half_angle  <= cfg_wdata[12:0];
				REG_WINDOW_MIN:    cfg_q.window_min_angle <= cfg_wdata[14:0];
				REG_WINDOW_MAX:    cfg_q.window_max_angle <= cfg_wdata[14:0];
				REG_SCAN_START:    cfg_q.scan_start_angle <= cfg_wdata[14:0];
				REG_ANGLE_STEP:    cfg_q.angle_step       <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/lcoa_angle_track.sv */
// sample angle tracking, window and cone decisions taken when a request is accepted
// depends on lcoa_pkg for cfg_t and item_t
module lcoa_angle_track
	import lcoa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        accept,
	input  logic [15:0] range_sample,
	input  logic        last_sample,
	output logic [17:0] angle_mag,
	output item_t       item
);

	logic signed [17:0] cur_angle_q;
	logic               at_start_q;

	logic signed [17:0] s;
	logic signed [18:0] s19;
	logic signed [18:0] nxt;
	logic signed [18:0] wmin;
	logic signed [18:0] wmax;
	logic               in_win;

	always_comb begin
		s    = at_start_q ? {{3{cfg.scan_start_angle[14]}}, cfg.scan_start_angle}
		                  : cur_angle_q;
		s19  = {s[17], s};
		nxt  = s19 + {6'b0, cfg.angle_step};
		wmin = {{4{cfg.window_min_angle[14]}}, cfg.window_min_angle};
		wmax = {{4{cfg.window_max_angle[14]}}, cfg.window_max_angle};
		// upper bound: last sample at its own angle, others one step ahead; lower bound always ahead
		in_win = (nxt > wmin) && (last_sample ? (s19 <= wmax) : (nxt <= wmax));
		angle_mag = s[17] ? 18'(~s + 18'sd1) : 18'(s);
	end

	always_comb begin
		item.range_sample = range_sample;
		item.last_sample  = last_sample;
		item.counts       = in_win;
		item.in_cone      = angle_mag <= {5'b0, cfg.cone_half_angle};
		item.near         = range_sample <= cfg.safe_distance;
		item.body_radius  = cfg.body_radius;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_angle_q <= -18'sd8192;
			at_start_q  <= 1'b1;
		end else if (accept) begin
			if (last_sample) begin
				at_start_q <= 1'b1;
			end else begin
				at_start_q  <= 1'b0;
				cur_angle_q <= nxt[17:0];
			end
		end
	end

endmodule

/* hw/rtl/lcoa_sine_pipe.sv */
// six-stage |sin(angle)| pipeline: reduce modulo pi, fold, scale to table index, rom read
// depends on lcoa_pkg for item_t, angle constants and the series constants
module lcoa_sine_pipe
	import lcoa_pkg::*;
#(
	parameter int unsigned SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [17:0] in_mag,
	input  item_t       in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output item_t       out_item,
	output logic [15:0] out_sine
);

	localparam int unsigned IDX_BIAS = ANG_HALF_PI / 2;
	localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int unsigned NW = $clog2(ANG_HALF_PI * SINE_TABLE_DEPTH + IDX_BIAS + 1);
	localparam longint unsigned IDX_RECIP = (64'd1 << NW) / ANG_HALF_PI;
	localparam longint unsigned IDX_C1 = IDX_RECIP * SINE_TABLE_DEPTH;
	localparam longint unsigned IDX_C2 = IDX_RECIP * IDX_BIAS;
	localparam int unsigned PW = NW + IW + 1;
	localparam int unsigned STAGES = 6;

	logic [STAGES-1:0] vld_q;
	logic [STAGES-1:0] rdy;

	logic [17:0]   mag_s1, mag_s2;
	logic [3:0]    quo_s2;
	logic [12:0]   fold_s3;
	logic [NW-1:0] num_s4;
	logic [IW-1:0] qe_s4;
	logic [IW-1:0] idx_s5;
	logic [15:0]   sine_s6;
	item_t         item_s1, item_s2, item_s3, item_s4, item_s5, item_s6;

	logic [36:0]   quo_prod;
	logic [17:0]   rem_pi;
	logic [14:0]   rem_c;
	logic [14:0]   rem_r;
	logic [12:0]   fold_v;
	logic [NW-1:0] num_v;
	logic [PW-1:0] qe_prod;
	logic [NW-1:0] rem_idx;
	logic [IW-1:0] idx_v;

	logic [15:0] sine_rom [SINE_TABLE_DEPTH+1];

	// taylor series of sin(x), x in q2.30, result q1.15 saturated
	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam longint unsigned X  = (longint'(k) * PI_Q30) / (64'd2 * SINE_TABLE_DEPTH);
		localparam longint unsigned X2 = (X * X) >> 30;
		localparam longint unsigned T1 = ((X * X2) >> 30) / 64'd6;
		localparam longint unsigned T2 = ((T1 * X2) >> 30) / 64'd20;
		localparam longint unsigned T3 = ((T2 * X2) >> 30) / 64'd42;
		localparam longint unsigned T4 = ((T3 * X2) >> 30) / 64'd72;
		localparam longint unsigned T5 = ((T4 * X2) >> 30) / 64'd110;
		localparam longint unsigned T6 = ((T5 * X2) >> 30) / 64'd156;
		localparam longint unsigned T7 = ((T6 * X2) >> 30) / 64'd210;
		localparam longint unsigned T8 = ((T7 * X2) >> 30) / 64'd272;
		localparam longint unsigned S1 = (X >= T1) ? X - T1 : 64'd0;
		localparam longint unsigned S2 = S1 + T2;
		localparam longint unsigned S3 = (S2 >= T3) ? S2 - T3 : 64'd0;
		localparam longint unsigned S4 = S3 + T4;
		localparam longint unsigned S5 = (S4 >= T5) ? S4 - T5 : 64'd0;
		localparam longint unsigned S6 = S5 + T6;
		localparam longint unsigned S7 = (S6 >= T7) ? S6 - T7 : 64'd0;
		localparam longint unsigned S8 = S7 + T8;
		localparam longint unsigned V  = (S8 * 64'd32768 + (Q30_ONE >> 1)) >> 30;
		assign sine_rom[k] = (V > 64'd32767) ? 16'd32767 : 16'(V);
	end

	// a stage takes new data when it is empty or its content moves on
	always_comb begin
		rdy[STAGES-1] = !vld_q[STAGES-1] || out_ready;
		for (int i = STAGES - 2; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[STAGES-1];
	assign out_item  = item_s6;
	assign out_sine  = sine_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) vld_q[0] <= in_valid;
			for (int i = 1; i < STAGES; i++) begin
				if (rdy[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// quotient estimate of |angle| / pi, low by at most one
	assign quo_prod = 37'(mag_s1) * 37'(MOD_RECIP);

	// remainder, one correction, fold into the first quadrant
	always_comb begin
		rem_pi = mag_s2 - 18'(quo_s2) * 18'(ANG_PI);
		rem_c  = rem_pi[14:0];
		rem_r  = (rem_c >= 15'(ANG_PI)) ? rem_c - 15'(ANG_PI) : rem_c;
		fold_v = (rem_r > 15'(ANG_HALF_PI)) ? 13'(15'(ANG_PI) - rem_r) : rem_r[12:0];
	end

	// rounded table index, the estimate is fixed up in the next stage
	always_comb begin
		num_v   = NW'(fold_s3) * NW'(SINE_TABLE_DEPTH) + NW'(IDX_BIAS);
		qe_prod = PW'(fold_s3) * PW'(IDX_C1) + PW'(IDX_C2);
		rem_idx = num_s4 - NW'(qe_s4) * NW'(ANG_HALF_PI);
		idx_v   = (rem_idx >= NW'(ANG_HALF_PI)) ? qe_s4 + IW'(1) : qe_s4;
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			mag_s1  <= in_mag;
			item_s1 <= in_item;
		end
		if (rdy[1]) begin
			mag_s2  <= mag_s1;
			quo_s2  <= quo_prod[MOD_SHIFT +: 4];
			item_s2 <= item_s1;
		end
		if (rdy[2]) begin
			fold_s3 <= fold_v;
			item_s3 <= item_s2;
		end
		if (rdy[3]) begin
			num_s4  <= num_v;
			qe_s4   <= qe_prod[NW +: IW];
			item_s4 <= item_s3;
		end
		if (rdy[4]) begin
			idx_s5  <= idx_v;
			item_s5 <= item_s4;
		end
		if (rdy[5]) begin
			sine_s6 <= sine_rom[idx_s5];
			item_s6 <= item_s5;
		end
	end

endmodule
